/* rtl/circular_double_ended_queue_core_defines.svh */
// Assertion macros used by the deque datapath.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDEQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define CDEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed (next cycle)");

`endif

/* rtl/cdeq_pkg.sv */
// Shared types, constants and index helpers for the circular deque.
package cdeq_pkg;

  localparam int DEPTH   = 8;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OCC_W   = 4;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 40;   // action + value, padded to bytes
  localparam int OUT_W   = 40;   // status + popped_value + occupancy, padded

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;  // capture input beat, start slot read
    logic exec;   // commit action, load result register
  } cmd_t;

  // Step an index one slot toward the rear, wrapping
  function automatic idx_t ring_next(input idx_t i);
    ring_next = (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // Step an index one slot toward the front, wrapping
  function automatic idx_t ring_prev(input idx_t i);
    ring_prev = (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

/* rtl/cdeq_ctrl.sv */
// Controller: sequences accept, slot read and commit, owns the result valid.
module cdeq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output cdeq_pkg::cmd_t  cmd
);

  cdeq_pkg::state_t state, state_next;
  logic             out_valid, out_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdeq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      cdeq_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = cdeq_pkg::S_EXEC;
        end
      end
      cdeq_pkg::S_EXEC: begin
        // commit only once the result register is free
        if (!out_valid || m_tready) begin
          cmd.exec   = 1'b1;
          state_next = cdeq_pkg::S_IDLE;
        end
      end
      default: state_next = cdeq_pkg::S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.exec | (out_valid & ~m_tready);
  assign m_tvalid       = out_valid;

endmodule

/* rtl/cdeq_datapath.sv */
// Datapath: slot ring, front/rear indices, element count and result register.
`include "circular_double_ended_queue_core_defines.svh"

module cdeq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cdeq_pkg::cmd_t                cmd,
  input  cdeq_pkg::action_t             in_action,
  input  cdeq_pkg::data_t               in_value,
  output cdeq_pkg::status_t             out_status,
  output cdeq_pkg::data_t               out_popped,
  output logic [cdeq_pkg::OCC_W-1:0]    out_occ
);

  cdeq_pkg::data_t   slots [cdeq_pkg::DEPTH];
  cdeq_pkg::data_t   rd_data;
  cdeq_pkg::action_t action;
  cdeq_pkg::data_t   value;
  cdeq_pkg::idx_t    head, head_next;
  cdeq_pkg::idx_t    tail, tail_next;
  cdeq_pkg::cnt_t    count, count_next;
  cdeq_pkg::idx_t    rd_addr, wr_addr;
  logic              wr_en;
  logic              is_push, is_full, is_empty;
  cdeq_pkg::status_t status_next;
  cdeq_pkg::data_t   popped_next;

  // Read address follows the incoming beat's end
  assign rd_addr = (in_action == cdeq_pkg::ACT_POP_FRONT) ? head : tail;

  // Capture the beat and read the slot it may pop
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action  <= in_action;
      value   <= in_value;
      rd_data <= slots[rd_addr];
    end
  end

  assign is_push  = (action == cdeq_pkg::ACT_PUSH_FRONT) ||
                    (action == cdeq_pkg::ACT_PUSH_REAR);
  assign is_full  = (count == cdeq_pkg::cnt_t'(cdeq_pkg::DEPTH));
  assign is_empty = (count == '0);

  // Action decode: next indices, count, write and result
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = '0;
    status_next = cdeq_pkg::STAT_DONE;
    popped_next = '0;
    if (is_push) begin
      if (is_full) begin
        status_next = cdeq_pkg::STAT_FULL;
      end else begin
        wr_en      = 1'b1;
        count_next = cdeq_pkg::cnt_t'(count + 1'b1);
        if (is_empty) begin
          head_next = '0;
          tail_next = '0;
          wr_addr   = '0;
        end else if (action == cdeq_pkg::ACT_PUSH_FRONT) begin
          head_next = cdeq_pkg::ring_prev(head);
          wr_addr   = head_next;
        end else begin
          tail_next = cdeq_pkg::ring_next(tail);
          wr_addr   = tail_next;
        end
      end
    end else begin
      if (is_empty) begin
        status_next = cdeq_pkg::STAT_EMPTY;
      end else begin
        popped_next = rd_data;
        count_next  = cdeq_pkg::cnt_t'(count - 1'b1);
        if (count == cdeq_pkg::cnt_t'(1)) begin
          // last element gone: back to empty
          head_next = '0;
          tail_next = '0;
        end else if (action == cdeq_pkg::ACT_POP_FRONT) begin
          head_next = cdeq_pkg::ring_next(head);
        end else begin
          tail_next = cdeq_pkg::ring_prev(tail);
        end
      end
    end
  end

  // Index and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Slot write
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slots[wr_addr] <= value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= status_next;
      out_popped <= popped_next;
      out_occ    <= cdeq_pkg::OCC_W'(count_next);
    end
  end

  // Checks
  `CDEQ_ASSERT_SAME(a_count_bound, 1'b1, count <= cdeq_pkg::cnt_t'(cdeq_pkg::DEPTH))
  `CDEQ_ASSERT_SAME(a_empty_indices, count == '0, (head == '0) && (tail == '0))
  `CDEQ_ASSERT_NEXT(a_refused_push_holds, cmd.exec && is_push && is_full, $stable(count) && $stable(head) && $stable(tail))
  `CDEQ_ASSERT_NEXT(a_pop_decrements, cmd.exec && !is_push && !is_empty, count == cdeq_pkg::cnt_t'($past(count) - 1'b1))

endmodule

/* rtl/circular_double_ended_queue_core.sv */
// Top level of the circular double-ended queue: stream ports, controller, datapath.
//
//   channel   dir  width  beat contents
//   s_axis    in   40     action[1:0], value[33:2]
//   m_axis    out  40     status[1:0], popped_value[33:2], occupancy[37:34]
//
// Each item first reads the slot ring, then commits.
// The next input is taken while a result waits.
// The commit stalls while the result register holds a beat not yet taken.
// Synchronous reset clears indices, count and valid; the slots are not cleared.
module circular_double_ended_queue_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [cdeq_pkg::IN_W-1:0]  s_tdata,   // action[1:0], value[33:2], zero pad
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cdeq_pkg::OUT_W-1:0] m_tdata    // status[1:0], popped_value[33:2],
                                                // occupancy[37:34], zero pad
);

  cdeq_pkg::cmd_t                 cmd;
  cdeq_pkg::status_t              out_status;
  cdeq_pkg::data_t                out_popped;
  logic [cdeq_pkg::OCC_W-1:0]     out_occ;

  cdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  cdeq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_action  (cdeq_pkg::action_t'(s_tdata[cdeq_pkg::ACT_W-1:0])),
    .in_value   (s_tdata[cdeq_pkg::ACT_W +: cdeq_pkg::DATA_W]),
    .out_status (out_status),
    .out_popped (out_popped),
    .out_occ    (out_occ)
  );

  // Pack the result beat
  assign m_tdata = {2'b00, out_occ, out_popped, out_status};

endmodule
